FILE: rtl/cgrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrc_pkg
// Shared constants, thermistor table and controller/datapath types for the
// gauge readout converter.
// ----------------------------------------------------------------------------
package cgrc_pkg;

  localparam int TABLE_ENTRIES = 29;
  localparam int SEG_W         = $clog2(TABLE_ENTRIES);
  localparam int CODE_W        = 12;
  localparam int TEMP_W        = 8;
  localparam int CUR_W         = 11;
  localparam int VOLT_W        = 13;
  localparam int HEALTH_W      = 2;

  localparam int TEMP_BASE = -40;
  localparam int TEMP_STEP = 5;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -8'sd45;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = TEMP_W'(TEMP_STEP * TABLE_ENTRIES - 45);

  localparam int CUR_ZERO  = 2048;
  localparam int CUR_GAIN  = 2929;
  localparam int CUR_DIV   = 10000;
  localparam int VOLT_GAIN = 112;
  localparam int VOLT_DIV  = 100;

  // Constant ratios as reciprocal multiplies, reciprocal rounded up; the shifts
  // keep the rounding error below one quotient step over the full code range
  localparam int     CUR_SHIFT  = 25;
  localparam int     VOLT_SHIFT = 17;
  localparam longint CUR_RECIP  = ((longint'(CUR_GAIN) << CUR_SHIFT) + CUR_DIV - 1)
                                  / CUR_DIV;
  localparam longint VOLT_RECIP = ((longint'(VOLT_GAIN) << VOLT_SHIFT) + VOLT_DIV - 1)
                                  / VOLT_DIV;
  localparam int     CPROD_W    = 36;   // max 2048*CUR_RECIP
  localparam int     VPROD_W    = 30;   // max 4095*VOLT_RECIP
  localparam int     TREM_W     = CODE_W + 3;

  localparam logic [HEALTH_W-1:0] HEALTH_GOOD     = 2'd0;
  localparam logic [HEALTH_W-1:0] HEALTH_COLD     = 2'd1;
  localparam logic [HEALTH_W-1:0] HEALTH_OVERHEAT = 2'd2;

  typedef struct packed {
    logic load;
    logic search_step;
    logic tdiv_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic search_end;
    logic search_interp;
    logic tdiv_last;
    logic out_free;
  } ctrl_sts_t;

  // Thermistor codes, strictly falling, one per 5 degree step from -40 C
  function automatic logic [CODE_W-1:0] therm_entry(input logic [SEG_W-1:0] idx);
    logic [CODE_W-1:0] val;
    case (idx)
      5'd0:    val = 12'd4020;
      5'd1:    val = 12'd3986;
      5'd2:    val = 12'd3939;
      5'd3:    val = 12'd3877;
      5'd4:    val = 12'd3759;
      5'd5:    val = 12'd3691;
      5'd6:    val = 12'd3562;
      5'd7:    val = 12'd3405;
      5'd8:    val = 12'd3222;
      5'd9:    val = 12'd3015;
      5'd10:   val = 12'd2787;
      5'd11:   val = 12'd2545;
      5'd12:   val = 12'd2296;
      5'd13:   val = 12'd2048;
      5'd14:   val = 12'd1808;
      5'd15:   val = 12'd1582;
      5'd16:   val = 12'd1374;
      5'd17:   val = 12'd1186;
      5'd18:   val = 12'd1020;
      5'd19:   val = 12'd874;
      5'd20:   val = 12'd747;
      5'd21:   val = 12'd639;
      5'd22:   val = 12'd546;
      5'd23:   val = 12'd467;
      5'd24:   val = 12'd400;
      5'd25:   val = 12'd343;
      5'd26:   val = 12'd295;
      5'd27:   val = 12'd254;
      5'd28:   val = 12'd220;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/cgrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrc_ctrl
// Sequencer: table scan, interpolation quotient loop, result hand-off.
// ----------------------------------------------------------------------------
module cgrc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output cgrc_pkg::ctrl_cmd_t  cmd_o,
  input  cgrc_pkg::ctrl_sts_t  sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_TDIV   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.search_end) begin
          state_d = sts_i.search_interp ? ST_TDIV : ST_DONE;
        end
      end
      ST_TDIV: begin
        cmd_o.tdiv_step = 1'b1;
        if (sts_i.tdiv_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/cgrc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrc_datapath
// Table scan, temperature interpolation, constant-ratio current and voltage
// scaling, health classing and the output register.
// ----------------------------------------------------------------------------
module cgrc_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cgrc_pkg::ctrl_cmd_t                   cmd_i,
  output cgrc_pkg::ctrl_sts_t                   sts_o,
  input  logic [cgrc_pkg::CODE_W-1:0]           therm_code_i,
  input  logic [cgrc_pkg::CODE_W-1:0]           current_code_i,
  input  logic [cgrc_pkg::CODE_W-1:0]           voltage_code_i,
  input  logic signed [cgrc_pkg::TEMP_W-1:0]    cold_limit_i,
  input  logic signed [cgrc_pkg::TEMP_W-1:0]    hot_limit_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic signed [cgrc_pkg::TEMP_W-1:0]    temp_celsius_o,
  output logic [cgrc_pkg::HEALTH_W-1:0]         health_class_o,
  output logic signed [cgrc_pkg::CUR_W-1:0]     current_ma_o,
  output logic [cgrc_pkg::VOLT_W-1:0]           voltage_mv_o
);

  // temperature path
  logic [cgrc_pkg::CODE_W-1:0]        code_q;
  logic [cgrc_pkg::SEG_W-1:0]         seg_q;
  logic signed [cgrc_pkg::TEMP_W-1:0] temp_q;
  logic [cgrc_pkg::CODE_W-1:0]        diff_q;
  logic [cgrc_pkg::TREM_W-1:0]        trem_q;
  logic [1:0]                         j_q;

  // current / voltage path
  logic                               cur_neg_q;
  logic [cgrc_pkg::CUR_W-1:0]         cur_abs_q;
  logic [cgrc_pkg::VOLT_W-1:0]        volt_mv_q;

  logic                               out_valid_q;

  logic [cgrc_pkg::CODE_W-1:0]        entry_cur;
  logic [cgrc_pkg::CODE_W-1:0]        entry_prev;
  logic                               hit;
  logic                               last;
  logic [cgrc_pkg::CODE_W-1:0]        offs;
  logic [cgrc_pkg::TREM_W-1:0]        numer;
  logic [cgrc_pkg::TREM_W-1:0]        tsub;
  logic signed [cgrc_pkg::TEMP_W-1:0] tdec;
  logic signed [cgrc_pkg::TEMP_W-1:0] upper;
  logic [cgrc_pkg::CODE_W-1:0]        cur_mag;
  logic [cgrc_pkg::CPROD_W-1:0]       cprod;
  logic [cgrc_pkg::VPROD_W-1:0]       vprod;
  logic [cgrc_pkg::HEALTH_W-1:0]      health;

  assign entry_cur  = cgrc_pkg::therm_entry(seg_q);
  assign entry_prev = cgrc_pkg::therm_entry(seg_q - 1'b1);
  assign hit        = code_q > entry_cur;
  assign last       = seg_q == cgrc_pkg::SEG_W'(cgrc_pkg::TABLE_ENTRIES - 1);
  assign offs       = code_q - entry_cur;
  assign numer      = (cgrc_pkg::TREM_W'(offs) << 2) + cgrc_pkg::TREM_W'(offs);
  assign upper      = cgrc_pkg::TEMP_W'(cgrc_pkg::TEMP_BASE
                                        + cgrc_pkg::TEMP_STEP * int'(seg_q));
  assign tsub       = cgrc_pkg::TREM_W'(diff_q) << j_q;
  assign tdec       = cgrc_pkg::TEMP_W'(3'b001 << j_q);

  assign cur_mag = current_code_i[cgrc_pkg::CODE_W-1]
                 ? {1'b0, current_code_i[cgrc_pkg::CODE_W-2:0]}
                 : cgrc_pkg::CODE_W'(cgrc_pkg::CUR_ZERO) - current_code_i;
  assign cprod   = cgrc_pkg::CPROD_W'(cur_mag) * cgrc_pkg::CPROD_W'(cgrc_pkg::CUR_RECIP);
  assign vprod   = cgrc_pkg::VPROD_W'(voltage_code_i)
                 * cgrc_pkg::VPROD_W'(cgrc_pkg::VOLT_RECIP);

  always_comb begin
    if (temp_q < cold_limit_i) begin
      health = cgrc_pkg::HEALTH_COLD;
    end else if (temp_q > hot_limit_i) begin
      health = cgrc_pkg::HEALTH_OVERHEAT;
    end else begin
      health = cgrc_pkg::HEALTH_GOOD;
    end
  end

  assign sts_o.search_end    = hit | last;
  assign sts_o.search_interp = hit & (seg_q != '0);
  assign sts_o.tdiv_last     = j_q == 2'd0;
  assign sts_o.out_free      = !out_valid_q || !out_stall_i;

  // table scan and interpolation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= therm_code_i;
      seg_q  <= '0;
    end else if (cmd_i.search_step) begin
      if (!(hit | last)) begin
        seg_q <= seg_q + 1'b1;
      end else if (hit && seg_q != '0) begin
        temp_q <= upper;
        diff_q <= entry_prev - entry_cur;
        trem_q <= numer;
        j_q    <= 2'd2;
      end else if (hit) begin
        temp_q <= cgrc_pkg::TEMP_LOW;
      end else begin
        temp_q <= cgrc_pkg::TEMP_HIGH;
      end
    end else if (cmd_i.tdiv_step) begin
      // one quotient bit per cycle, taken straight off the temperature
      if (trem_q >= tsub) begin
        trem_q <= trem_q - tsub;
        temp_q <= temp_q - tdec;
      end
      j_q <= j_q - 1'b1;
    end
  end

  // current and voltage: scale on the input beat by reciprocal multiplication
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_neg_q <= !current_code_i[cgrc_pkg::CODE_W-1];
      cur_abs_q <= cprod[cgrc_pkg::CUR_SHIFT +: cgrc_pkg::CUR_W];
      volt_mv_q <= vprod[cgrc_pkg::VOLT_SHIFT +: cgrc_pkg::VOLT_W];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      temp_celsius_o <= temp_q;
      health_class_o <= health;
      current_ma_o   <= cur_neg_q ? cgrc_pkg::CUR_W'(0) - cur_abs_q : cur_abs_q;
      voltage_mv_o   <= volt_mv_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/charger_gauge_readout_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charger_gauge_readout_converter_core
// Converts one raw gauge sample into temperature, health class, current and
// voltage; cold and hot limits sit behind an APB-style register port.
// ----------------------------------------------------------------------------
// The thermistor table is scanned one entry a cycle, interpolation adds a quotient
// loop, and the result is loaded into the output register once it is free; current and
// voltage are scaled on the input beat. Throughput: one item at a time; the next
// input beat is taken the cycle after the result enters the output register.
// Reset: limits return to 10 and 60, no result pending, ready for input.
module charger_gauge_readout_converter_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cgrc_pkg::CODE_W-1:0]           therm_code_i,
  input  logic [cgrc_pkg::CODE_W-1:0]           current_code_i,
  input  logic [cgrc_pkg::CODE_W-1:0]           voltage_code_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cgrc_pkg::TEMP_W-1:0]    temp_celsius_o,
  output logic [cgrc_pkg::HEALTH_W-1:0]         health_class_o,
  output logic signed [cgrc_pkg::CUR_W-1:0]     current_ma_o,
  output logic [cgrc_pkg::VOLT_W-1:0]           voltage_mv_o
);

  localparam logic REG_COLD = 1'b0;
  localparam logic REG_HOT  = 1'b1;

  logic signed [cgrc_pkg::TEMP_W-1:0] cold_q;
  logic signed [cgrc_pkg::TEMP_W-1:0] hot_q;
  logic                               wr_en;
  logic                               reg_idx;
  cgrc_pkg::ctrl_cmd_t                cmd;
  cgrc_pkg::ctrl_sts_t                sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cold_q <= 8'sd10;
      hot_q  <= 8'sd60;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COLD: cold_q <= pwdata[cgrc_pkg::TEMP_W-1:0];
        REG_HOT:  hot_q  <= pwdata[cgrc_pkg::TEMP_W-1:0];
        default: begin
          cold_q <= cold_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLD: prdata = 32'(cold_q);
      REG_HOT:  prdata = 32'(hot_q);
      default:  prdata = '0;
    endcase
  end

  cgrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  cgrc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .therm_code_i   (therm_code_i),
    .current_code_i (current_code_i),
    .voltage_code_i (voltage_code_i),
    .cold_limit_i   (cold_q),
    .hot_limit_i    (hot_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .temp_celsius_o (temp_celsius_o),
    .health_class_o (health_class_o),
    .current_ma_o   (current_ma_o),
    .voltage_mv_o   (voltage_mv_o)
  );

endmodule
